### rtl/nzbb_pkg.sv
// Shared widths, register indexes, reset values and types for the bounding box core.
`default_nettype none
package nzbb_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int PAD_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;

  localparam int DEFAULT_MAX_DIM = 4096;
  // largest value a size register can hold
  localparam int CFG_MAX = (1 << CFG_W) - 1;

  // result item tdata: left, right, top, bottom, crop width, crop height, max index
  localparam int RES_BITS = 4 * COORD_W + 2 * SIZE_W + PIX_W;
  localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;
  localparam int S_TDATA_W = ((PIX_W + 7) / 8) * 8;

  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ROW_PAD      = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [PAD_W-1:0] RST_ROW_PAD      = 2'd0;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [PAD_W-1:0] row_pad;
  } nzbb_cfg_t;

  typedef struct packed {
    logic               found;
    logic [PIX_W-1:0]   max_index;
    logic [SIZE_W-1:0]  crop_height;
    logic [SIZE_W-1:0]  crop_width;
    logic [COORD_W-1:0] box_bottom;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_left;
  } nzbb_result_t;

endpackage
`default_nettype wire

### rtl/nonzero_pixel_bounding_box_core.sv
// Top level of the bounding box core: config registers, input, tracker and result stages.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata[7:0] pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata: box, crop size, max index; tuser found
//  cfg       in   cfg_we (no wait)                 cfg_index, cfg_data
//
// One pixel item per clock sustained unless a waiting result stalls the tracker; each byte
// passes the input register and is then folded into the trackers; the frame's last byte
// also loads the result register; the result item is valid from the cycle after that load.
// Reset loads 640x480 with no row pad and clears counters and trackers.
// A waiting result stalls the tracker only on the last byte of the next frame;
// the input stalls with it until the result item is taken.
`default_nettype none
module nonzero_pixel_bounding_box_core #(
  parameter int MAX_DIM = nzbb_pkg::DEFAULT_MAX_DIM
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] pixel
  input  wire logic [nzbb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [11:0] box_left, [23:12] box_right, [35:24] box_top, [47:36] box_bottom,
  // [60:48] crop_width, [73:61] crop_height, [81:74] max_index, rest zero
  output logic [nzbb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] found
  output logic                                m_axis_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [nzbb_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [nzbb_pkg::CFG_W-1:0]     cfg_data
);
  import nzbb_pkg::*;

  nzbb_cfg_t        cfg;
  logic             held_valid;
  logic [PIX_W-1:0] held_pixel;
  logic             advance;
  logic             step;
  logic             frame_end;
  nzbb_result_t     result;
  nzbb_result_t     out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.row_pad      <= RST_ROW_PAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        REG_ROW_PAD:      cfg.row_pad      <= cfg_data[PAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // hold the tracker only when this byte ends a frame and the result slot is full
  assign advance = !frame_end || !m_axis_tvalid || m_axis_tready;
  assign step    = held_valid && advance;

  nzbb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_pixel   (s_axis_tdata[PIX_W-1:0]),
    .advance    (advance),
    .held_valid (held_valid),
    .held_pixel (held_pixel)
  );

  nzbb_track #(
    .MAX_DIM (MAX_DIM)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .pixel     (held_pixel),
    .frame_end (frame_end),
    .result    (result)
  );

  nzbb_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (step && frame_end),
    .load_result (result),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (out_result)
  );

  assign m_axis_tdata = M_TDATA_W'({out_result.max_index, out_result.crop_height,
                                    out_result.crop_width, out_result.box_bottom,
                                    out_result.box_top, out_result.box_right,
                                    out_result.box_left});
  assign m_axis_tuser = out_result.found;

endmodule
`default_nettype wire

### rtl/nzbb_in_reg.sv
// Input register: holds one accepted pixel item until the tracker takes it.
`default_nettype none
module nzbb_in_reg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [nzbb_pkg::PIX_W-1:0] in_pixel,
  input  wire logic                     advance,
  output logic                          held_valid,
  output logic [nzbb_pkg::PIX_W-1:0]    held_pixel
);
  import nzbb_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_pixel <= in_pixel;
    end
  end

endmodule
`default_nettype wire

### rtl/nzbb_track.sv
// Raster counters and box trackers; forms the frame result on the last byte.
`default_nettype none
module nzbb_track #(
  parameter int MAX_DIM = nzbb_pkg::DEFAULT_MAX_DIM
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire nzbb_pkg::nzbb_cfg_t        cfg,
  input  wire logic                       step,
  input  wire logic [nzbb_pkg::PIX_W-1:0] pixel,
  output logic                            frame_end,
  output nzbb_pkg::nzbb_result_t          result
);
  import nzbb_pkg::*;

  // sizes above the register range can never be reached
  localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
  localparam int DIM_W   = $clog2(EFF_MAX + 1);
  localparam int CNT_W   = $clog2(EFF_MAX + (1 << PAD_W) - 1);
  localparam int POS_W   = $clog2(EFF_MAX);
  localparam int SUM_W   = CNT_W + 1;
  localparam int RSUM_W  = POS_W + 1;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(EFF_MAX);

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [POS_W-1:0] row_count, row_count_next;
  logic [POS_W-1:0] min_column, min_column_next;
  logic [POS_W-1:0] max_column, max_column_next;
  logic [POS_W-1:0] first_row, first_row_next;
  logic [POS_W-1:0] last_row, last_row_next;
  logic             seen_any, seen_any_next;
  logic [PIX_W-1:0] peak_value, peak_value_next;

  logic [DIM_W-1:0] w, h;
  logic             in_row;
  logic             row_end;
  logic [POS_W-1:0] col_pos;
  logic [RSUM_W-1:0] crop_w, crop_h;

  // treat zero as one and clip to the largest supported size
  always_comb begin
    if (cfg.frame_width == '0) begin
      w = DIM_W'(1);
    end else if (32'(cfg.frame_width) > 32'(EFF_MAX)) begin
      w = DIM_CAP;
    end else begin
      w = DIM_W'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h = DIM_W'(1);
    end else if (32'(cfg.frame_height) > 32'(EFF_MAX)) begin
      h = DIM_CAP;
    end else begin
      h = DIM_W'(cfg.frame_height);
    end
  end

  assign in_row    = CNT_W'(column_count) < CNT_W'(w);
  assign col_pos   = POS_W'(column_count);
  assign row_end   = (SUM_W'(column_count) + SUM_W'(1)) >= (SUM_W'(w) + SUM_W'(cfg.row_pad));
  assign frame_end = row_end && ((RSUM_W'(row_count) + RSUM_W'(1)) >= RSUM_W'(h));

  always_comb begin
    min_column_next = min_column;
    max_column_next = max_column;
    first_row_next  = first_row;
    last_row_next   = last_row;
    seen_any_next   = seen_any;
    peak_value_next = peak_value;

    // pad bytes leave the trackers alone
    if (in_row) begin
      if (pixel > peak_value) begin
        peak_value_next = pixel;
      end
      if (pixel != '0) begin
        if (!seen_any) begin
          first_row_next  = row_count;
          min_column_next = col_pos;
          max_column_next = col_pos;
        end else begin
          if (col_pos < min_column) begin
            min_column_next = col_pos;
          end
          if (col_pos > max_column) begin
            max_column_next = col_pos;
          end
        end
        last_row_next = row_count;
        seen_any_next = 1'b1;
      end
    end

    if (!row_end) begin
      column_count_next = column_count + CNT_W'(1);
      row_count_next    = row_count;
    end else if (!frame_end) begin
      column_count_next = '0;
      row_count_next    = row_count + POS_W'(1);
    end else begin
      column_count_next = '0;
      row_count_next    = '0;
    end
  end

  assign crop_w = RSUM_W'(max_column_next) - RSUM_W'(min_column_next) + RSUM_W'(1);
  assign crop_h = RSUM_W'(last_row_next) - RSUM_W'(first_row_next) + RSUM_W'(1);

  always_comb begin
    result.max_index = peak_value_next;
    result.found     = seen_any_next;
    if (seen_any_next) begin
      result.box_left    = COORD_W'(min_column_next);
      result.box_right   = COORD_W'(max_column_next);
      result.box_top     = COORD_W'(first_row_next);
      result.box_bottom  = COORD_W'(last_row_next);
      result.crop_width  = SIZE_W'(crop_w);
      result.crop_height = SIZE_W'(crop_h);
    end else begin
      result.box_left    = '0;
      result.box_right   = '0;
      result.box_top     = '0;
      result.box_bottom  = '0;
      result.crop_width  = '0;
      result.crop_height = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      min_column   <= '1;
      max_column   <= '0;
      first_row    <= '0;
      last_row     <= '0;
      seen_any     <= 1'b0;
      peak_value   <= '0;
    end else if (step) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (frame_end) begin
        // clear for the next frame
        min_column <= '1;
        max_column <= '0;
        first_row  <= '0;
        last_row   <= '0;
        seen_any   <= 1'b0;
        peak_value <= '0;
      end else begin
        min_column <= min_column_next;
        max_column <= max_column_next;
        first_row  <= first_row_next;
        last_row   <= last_row_next;
        seen_any   <= seen_any_next;
        peak_value <= peak_value_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/nzbb_out_reg.sv
// Result register: holds the frame result item until the sink takes it.
`default_nettype none
module nzbb_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire nzbb_pkg::nzbb_result_t load_result,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output nzbb_pkg::nzbb_result_t      out_result
);
  import nzbb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule
`default_nettype wire
